// ----- hdl/lathe_mesh_vertex_generator_assert.svh -----
// Assertion macros shared by the lathe mesh vertex generator RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef LATHE_MESH_VERTEX_GENERATOR_ASSERT_SVH
`define LATHE_MESH_VERTEX_GENERATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define LMVG_ASSERT_IMP(label, cond, conseq) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (conseq)) \
        else $error("lmvg: same-cycle check failed");

// next-cycle implication, off during reset
`define LMVG_ASSERT_NXT(label, cond, conseq) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (conseq)) \
        else $error("lmvg: next-cycle check failed");

`endif

// ----- hdl/lmvg_pkg.sv -----
// Shared constants and helpers for the lathe mesh vertex generator.
// No dependencies.
`default_nettype none

package lmvg_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_RING_COUNT    = 3'd0;
    localparam logic [2:0] REG_SEGMENT_COUNT = 3'd1;
    localparam logic [2:0] REG_LATHE_RADIUS  = 3'd2;
    localparam logic [2:0] REG_TOTAL_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_SWEEP_START   = 3'd4;
    localparam logic [2:0] REG_SWEEP_END     = 3'd5;
    localparam logic [2:0] REG_INDEX_BASE    = 3'd6;

    // input kinds
    localparam logic MODE_VERTEX = 1'b0;
    localparam logic MODE_INDEX  = 1'b1;

    // corner number of the sixth triangle index
    localparam logic [2:0] IDX_LAST = 3'd5;

    // divider: 17 quotient bits, remainder below twice a count of 255
    localparam int DIV_Q_W   = 17;
    localparam int DIV_REM_W = 10;

    // sine unit depth and quarter-wave coefficients (Q30, z^9 first)
    localparam int SIN_STAGES = 7;
    localparam logic [30:0] SIN_COEF [5] = '{
        31'd172272, 31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
    };
    localparam logic [31:0] SIN_ONE = 32'd1073741824;

    // arithmetic shift right with rounding half away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic        neg;
        logic [63:0] m;
        neg = v[63];
        m   = neg ? 64'(-v) : 64'(v);
        m   = (m + (64'd1 << (sh - 1))) >> sh;
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lmvg_div.sv -----
// Pipelined restoring divider, one quotient bit per stage: (rem:count)/(2*count).
// Depends on lmvg_pkg.
`default_nettype none

module lmvg_div
    import lmvg_pkg::*;
(
    input  wire                  aclk,
    input  wire [DIV_Q_W-1:0]    en,
    input  wire [DIV_REM_W-1:0]  rem_init,
    input  wire [7:0]            count,
    output logic [DIV_Q_W-1:0]   quot
);

    logic [DIV_REM_W-1:0] rem_reg  [DIV_Q_W];
    logic [DIV_REM_W-1:0] rem_next [DIV_Q_W];
    logic [DIV_Q_W-1:0]   q_reg    [DIV_Q_W];
    logic [DIV_Q_W-1:0]   q_next   [DIV_Q_W];
    logic [DIV_Q_W-1:0]   cnt_ext;
    logic [DIV_REM_W:0]   dsr;

    assign cnt_ext = DIV_Q_W'(count);
    assign dsr     = (DIV_REM_W + 1)'({count, 1'b0});

    // one trial subtraction per stage, low dividend bits come from the count
    always_comb begin
        logic [DIV_REM_W-1:0] rin;
        logic [DIV_Q_W-1:0]   qin;
        logic [DIV_REM_W:0]   trial;
        for (int k = 0; k < DIV_Q_W; k++) begin
            rin   = (k == 0) ? rem_init : rem_reg[(k == 0) ? 0 : k - 1];
            qin   = (k == 0) ? '0 : q_reg[(k == 0) ? 0 : k - 1];
            trial = {rin, cnt_ext[DIV_Q_W - 1 - k]};
            if (trial >= dsr) begin
                rem_next[k] = DIV_REM_W'(trial - dsr);
                q_next[k]   = {qin[DIV_Q_W-2:0], 1'b1};
            end else begin
                rem_next[k] = DIV_REM_W'(trial);
                q_next[k]   = {qin[DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_Q_W; k++) begin
            if (en[k]) begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign quot = q_reg[DIV_Q_W-1];

endmodule

`default_nettype wire

// ----- hdl/lmvg_sin.sv -----
// Pipelined sine of a 17 bit angle (2 pi = 131072), Q30 signed result.
// Quarter-wave odd polynomial in Horner form. Depends on lmvg_pkg.
`default_nettype none

module lmvg_sin
    import lmvg_pkg::*;
(
    input  wire                    aclk,
    input  wire [SIN_STAGES-1:0]   en,
    input  wire [16:0]             angle,
    output logic signed [31:0]     sine
);

    logic [30:0] z_reg   [5];
    logic [30:0] z2_reg  [4];
    logic [61:0] p_reg   [6];
    logic [61:0] p_next  [6];
    logic        neg_reg [6];
    logic signed [31:0] sine_reg;
    logic signed [31:0] sine_next;
    logic [15:0] x0;
    logic [30:0] z0;
    logic [30:0] z2_next;

    // fold into the first quadrant
    always_comb begin
        x0 = angle[15] ? 16'(17'd32768 - {2'b0, angle[14:0]}) : {1'b0, angle[14:0]};
        z0 = {x0, 15'd0};
        z2_next = p_reg[0][60:30];
    end

    // square the argument, then Horner steps: t = c - (p >> 30), z2 * t (z * t at the end)
    always_comb begin
        logic [30:0] t;
        p_next[0] = 62'(z0) * 62'(z0);
        p_next[1] = 62'(z2_next) * 62'(SIN_COEF[0]);
        for (int i = 2; i < 6; i++) begin
            t = SIN_COEF[i-1] - 31'(p_reg[i-1] >> 30);
            if (i == 5) p_next[i] = 62'(z_reg[4]) * 62'(t);
            else        p_next[i] = 62'(z2_reg[(i < 5) ? i - 2 : 0]) * 62'(t);
        end
    end

    // clamp to one and apply the half-wave sign
    always_comb begin
        logic [31:0] s;
        s = p_reg[5][61:30];
        if (s > SIN_ONE) s = SIN_ONE;
        sine_next = neg_reg[5] ? -$signed(s) : $signed(s);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            z_reg[0]   <= z0;
            p_reg[0]   <= p_next[0];
            neg_reg[0] <= angle[16];
        end
        if (en[1]) begin
            z_reg[1]   <= z_reg[0];
            z2_reg[0]  <= z2_next;
            p_reg[1]   <= p_next[1];
            neg_reg[1] <= neg_reg[0];
        end
        for (int i = 2; i < 5; i++) begin
            if (en[i]) begin
                z_reg[i]    <= z_reg[i-1];
                z2_reg[i-1] <= z2_reg[i-2];
                p_reg[i]    <= p_next[i];
                neg_reg[i]  <= neg_reg[i-1];
            end
        end
        if (en[5]) begin
            p_reg[5]   <= p_next[5];
            neg_reg[5] <= neg_reg[4];
        end
        if (en[6]) begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

`default_nettype wire

// ----- hdl/lathe_mesh_vertex_generator.sv -----
// Lathe mesh vertex generator top level: config registers, stage control, maths.
// Depends on lmvg_pkg, lmvg_div, lmvg_sin and the assertion macro header.
//
// Each input transfer names a grid point (vertex mode) or a grid quad (index
// mode). The datapath is a 31-stage pipeline: an input stage, a 17-stage
// divider for the uv, two stages for the ring angle, a 7-stage sine unit (four
// copies), and four stages for normal and position. A vertex or an out-of-grid
// item gives one result and the pipeline takes one item per cycle while the
// output accepts; an index item gives six results in turn from the output
// stage, which holds the pipeline behind it until the last one is taken. Idle
// stages keep accepting while the output waits. No clearing pass after reset.
// Registers must be written only while the pipeline is empty.
`default_nettype none

module lathe_mesh_vertex_generator
    import lmvg_pkg::*;
#(
    parameter int GRID_BITS = 8,
    parameter int FRAC_BITS = 12
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    // input: tdata = ring_index, segment_index; tuser = mode
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire [((2 * GRID_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  wire                  s_tuser,
    // output: tdata = pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
    //         index_value; tuser = range_error
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [((3 * (FRAC_BITS + 10) + 114 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast,
    // register writes
    input  wire                  cfg_we,
    input  wire [2:0]            cfg_addr,
    input  wire [31:0]           cfg_wdata
);

    localparam int POS_W  = FRAC_BITS + 10;
    localparam int DATA_W = 3 * POS_W + 3 * 16 + 2 * 17 + 32;
    localparam int CW     = (GRID_BITS > 8) ? GRID_BITS : 8;
    localparam int OW     = GRID_BITS + 9;

    // stage map
    localparam int ST_DIV0 = 1;
    localparam int ST_A1   = ST_DIV0 + DIV_Q_W;
    localparam int ST_A2   = ST_A1 + 1;
    localparam int ST_SIN0 = ST_A2 + 1;
    localparam int ST_P1   = ST_SIN0 + SIN_STAGES;
    localparam int ST_P2   = ST_P1 + 1;
    localparam int ST_P3   = ST_P2 + 1;
    localparam int ST_OUT  = ST_P3 + 1;
    localparam int NS      = ST_OUT + 1;

    typedef struct packed {
        logic          mode;
        logic          ok;
        logic          yup;
        logic [OW-1:0] off;
        logic [16:0]   tu;
        logic [16:0]   tv;
    } item_t;

    // configuration registers
    logic [7:0]  ring_count_reg;
    logic [7:0]  segment_count_reg;
    logic [19:0] lathe_radius_reg;
    logic [19:0] total_height_reg;
    logic [16:0] sweep_start_reg;
    logic [16:0] sweep_end_reg;
    logic [31:0] index_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_count_reg    <= 8'd16;
            segment_count_reg <= 8'd16;
            lathe_radius_reg  <= 20'd2048;
            total_height_reg  <= 20'd0;
            sweep_start_reg   <= 17'd0;
            sweep_end_reg     <= 17'd65536;
            index_base_reg    <= 32'd0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_RING_COUNT:    ring_count_reg    <= cfg_wdata[7:0];
                REG_SEGMENT_COUNT: segment_count_reg <= cfg_wdata[7:0];
                REG_LATHE_RADIUS:  lathe_radius_reg  <= cfg_wdata[19:0];
                REG_TOTAL_HEIGHT:  total_height_reg  <= cfg_wdata[19:0];
                REG_SWEEP_START:   sweep_start_reg   <= cfg_wdata[16:0];
                REG_SWEEP_END:     sweep_end_reg     <= cfg_wdata[16:0];
                REG_INDEX_BASE:    index_base_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage control: a stage loads when empty or when its successor loads
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;
    logic [2:0]    k_reg;
    logic [2:0]    k_next;
    logic          out_last;
    logic          out_xfer;
    logic          out_done;

    assign out_xfer = v_reg[ST_OUT] && m_tready;
    assign out_done = out_xfer && out_last;

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || out_done;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= s_tvalid;
            for (int i = 1; i < NS; i++) begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // input stage: grid check and quad offset
    logic [GRID_BITS-1:0] in_ring;
    logic [GRID_BITS-1:0] in_seg;
    logic [GRID_BITS-1:0] ring_reg;
    logic [GRID_BITS-1:0] seg_reg;
    logic [CW-1:0]        ring_c;
    logic [CW-1:0]        seg_c;
    logic [CW-1:0]        rc_c;
    logic [CW-1:0]        sc_c;
    logic                 in_ok;
    logic [8:0]           stride;

    assign in_ring = s_tdata[GRID_BITS-1:0];
    assign in_seg  = s_tdata[2*GRID_BITS-1:GRID_BITS];
    assign ring_c  = CW'(in_ring);
    assign seg_c   = CW'(in_seg);
    assign rc_c    = CW'(ring_count_reg);
    assign sc_c    = CW'(segment_count_reg);
    assign stride  = {1'b0, segment_count_reg} + 9'd1;

    always_comb begin
        if (s_tuser == MODE_VERTEX) begin
            in_ok = (ring_count_reg != 8'd0) && (segment_count_reg != 8'd0) &&
                    (ring_c <= rc_c) && (seg_c <= sc_c);
        end else begin
            in_ok = (ring_c < rc_c) && (seg_c < sc_c);
        end
    end

    item_t sb_reg  [NS];
    item_t sb_next [NS];
    logic  [DIV_Q_W-1:0] tu_q;
    logic  [DIV_Q_W-1:0] tv_q;
    logic  a2_yup;

    always_comb begin
        sb_next[0].mode = s_tuser;
        sb_next[0].ok   = in_ok;
        sb_next[0].yup  = 1'b0;
        sb_next[0].off  = OW'(in_ring) * OW'(stride) + OW'(in_seg);
        sb_next[0].tu   = '0;
        sb_next[0].tv   = '0;
        for (int i = 1; i < NS; i++) begin
            sb_next[i] = sb_reg[i-1];
        end
        sb_next[ST_A1].tu  = tu_q;
        sb_next[ST_A1].tv  = tv_q;
        sb_next[ST_A2].yup = a2_yup;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ring_reg <= in_ring;
            seg_reg  <= in_seg;
        end
        for (int i = 0; i < NS; i++) begin
            if (en[i]) sb_reg[i] <= sb_next[i];
        end
    end

    // uv: round(index * 65536 / count)
    lmvg_div u_div_u (
        .aclk     (aclk),
        .en       (en[ST_DIV0 +: DIV_Q_W]),
        .rem_init (DIV_REM_W'(seg_reg)),
        .count    (segment_count_reg),
        .quot     (tu_q)
    );

    lmvg_div u_div_v (
        .aclk     (aclk),
        .en       (en[ST_DIV0 +: DIV_Q_W]),
        .rem_init (DIV_REM_W'(ring_reg)),
        .count    (ring_count_reg),
        .quot     (tv_q)
    );

    // ring angle: sweep scaled by v
    logic signed [17:0] sweep_diff;
    logic signed [35:0] prod_reg;
    logic signed [19:0] phi;
    logic [16:0]        ang_reg  [4];
    logic [16:0]        ang_next [4];

    assign sweep_diff = $signed({1'b0, sweep_end_reg}) - $signed({1'b0, sweep_start_reg});

    always_comb begin
        phi = $signed(20'(sweep_start_reg)) +
              $signed(20'(rnd_shift(64'(prod_reg), 16)));
        a2_yup = (phi <= 20'sd32768);
        ang_next[0] = phi[16:0];
        ang_next[1] = phi[16:0] + 17'd32768;
        ang_next[2] = {sb_reg[ST_A1].tu[15:0], 1'b0};
        ang_next[3] = {sb_reg[ST_A1].tu[15:0], 1'b0} + 17'd32768;
    end

    always_ff @(posedge aclk) begin
        if (en[ST_A1]) prod_reg <= sweep_diff * $signed({1'b0, tv_q});
        if (en[ST_A2]) begin
            for (int j = 0; j < 4; j++) ang_reg[j] <= ang_next[j];
        end
    end

    // sine and cosine of ring and segment angles
    logic signed [31:0] sin_val [4];

    for (genvar g = 0; g < 4; g++) begin : g_sin
        lmvg_sin u_sin (
            .aclk  (aclk),
            .en    (en[ST_SIN0 +: SIN_STAGES]),
            .angle (ang_reg[g]),
            .sine  (sin_val[g])
        );
    end

    // normal and position
    logic signed [63:0] nxr_reg, nzr_reg;
    logic signed [31:0] cp1_reg;
    logic signed [31:0] nx_reg, ny_reg, nz_reg;
    logic signed [52:0] px_reg, py_reg, pz_reg;
    logic signed [20:0] rad_s;
    logic [15:0]        n16x_reg, n16y_reg, n16z_reg;
    logic signed [21:0] hdiff;
    logic signed [63:0] hh;
    logic signed [63:0] yoff;
    logic [POS_W-1:0]   posx_reg, posy_reg, posz_reg;
    logic [15:0]        nx_o_reg, ny_o_reg, nz_o_reg;
    logic [31:0]        a_reg, b_reg;
    logic [31:0]        a_next;

    assign rad_s = $signed({1'b0, lathe_radius_reg});
    assign hdiff = $signed({2'b0, total_height_reg}) - $signed({1'b0, lathe_radius_reg, 1'b0});
    assign hh    = (hdiff > 22'sd0) ? 64'(hdiff >>> 1) : 64'sd0;
    assign yoff  = sb_reg[ST_P3].yup ? hh : -hh;
    assign a_next = index_base_reg + 32'(sb_reg[ST_P3].off);

    always_ff @(posedge aclk) begin
        if (en[ST_P1]) begin
            nxr_reg <= sin_val[0] * sin_val[2];
            nzr_reg <= sin_val[0] * sin_val[3];
            cp1_reg <= sin_val[1];
        end
        if (en[ST_P2]) begin
            nx_reg <= 32'(rnd_shift(nxr_reg, 30));
            nz_reg <= 32'(rnd_shift(nzr_reg, 30));
            ny_reg <= cp1_reg;
        end
        if (en[ST_P3]) begin
            px_reg   <= nx_reg * rad_s;
            py_reg   <= ny_reg * rad_s;
            pz_reg   <= nz_reg * rad_s;
            n16x_reg <= 16'(rnd_shift(64'(nx_reg), 16));
            n16y_reg <= 16'(rnd_shift(64'(ny_reg), 16));
            n16z_reg <= 16'(rnd_shift(64'(nz_reg), 16));
        end
        if (en[ST_OUT]) begin
            posx_reg <= POS_W'(rnd_shift(64'(px_reg), 30));
            posy_reg <= POS_W'(rnd_shift(64'(py_reg), 30) + yoff);
            posz_reg <= POS_W'(rnd_shift(64'(pz_reg), 30));
            nx_o_reg <= n16x_reg;
            ny_o_reg <= n16y_reg;
            nz_o_reg <= n16z_reg;
            a_reg    <= a_next;
            b_reg    <= a_next + 32'(stride);
        end
    end

    // output: six corners in index mode, one result otherwise
    item_t       tail;
    logic [31:0] idx_val;

    assign tail = sb_reg[ST_OUT];

    always_comb begin
        case (k_reg)
            3'd0:    idx_val = a_reg;
            3'd1:    idx_val = b_reg;
            3'd2:    idx_val = a_reg + 32'd1;
            3'd3:    idx_val = a_reg + 32'd1;
            3'd4:    idx_val = b_reg;
            3'd5:    idx_val = b_reg + 32'd1;
            default: idx_val = a_reg;
        endcase
    end

    always_comb begin
        m_tdata  = '0;
        m_tuser  = 1'b0;
        out_last = 1'b1;
        if (!tail.ok) begin
            m_tuser = 1'b1;
        end else if (tail.mode == MODE_INDEX) begin
            m_tdata[DATA_W-1 -: 32] = idx_val;
            out_last = (k_reg == IDX_LAST);
        end else begin
            m_tdata[DATA_W-33:0] = {tail.tv, tail.tu, nz_o_reg, ny_o_reg, nx_o_reg,
                                    posz_reg, posy_reg, posx_reg};
        end
    end

    assign m_tvalid = v_reg[ST_OUT];
    assign m_tlast  = out_last;

    always_comb begin
        k_next = k_reg;
        if (out_done)      k_next = 3'd0;
        else if (out_xfer) k_next = k_reg + 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) k_reg <= 3'd0;
        else          k_reg <= k_next;
    end

    // checks
    `include "lathe_mesh_vertex_generator_assert.svh"

    `LMVG_ASSERT_NXT(a_k_hold, m_tvalid && !m_tready, $stable(k_reg) && m_tvalid)
    `LMVG_ASSERT_IMP(a_k_index_only, k_reg != 3'd0, m_tvalid && tail.ok && tail.mode == MODE_INDEX)
    `LMVG_ASSERT_IMP(a_err_last, m_tvalid && m_tuser, m_tlast)
    `LMVG_ASSERT_IMP(a_full_stall, !s_tready, v_reg[ST_OUT] && !out_done)

endmodule

`default_nettype wire

// ----- dv/lmvg_checker.sv -----
// Scoreboard for the lathe mesh vertex generator: watches both streams and the
// register port, predicts every result and compares it. Depends on lmvg_pkg.
`timescale 1ns / 100ps

module lmvg_checker
    import lmvg_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire [15:0]  s_tdata,
    input  wire         s_tuser,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire [183:0] m_tdata,
    input  wire         m_tuser,
    input  wire         m_tlast,
    input  wire         cfg_we,
    input  wire [2:0]   cfg_addr,
    input  wire [31:0]  cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    typedef struct packed {
        logic [21:0] pos_x, pos_y, pos_z;
        logic [15:0] norm_x, norm_y, norm_z;
        logic [16:0] tex_u, tex_v;
        logic [31:0] index_value;
        logic        last, range_error;
    } vertex_out_t;

    vertex_out_t vertex_q[$];

    // shadow of the register file
    logic [7:0]  rings, segs;
    logic [19:0] radius, height;
    logic [16:0] sweep_lo, sweep_hi;
    logic [31:0] vbase;

    function automatic longint unsigned quarter_sine(input longint unsigned x);
        longint unsigned z, z2, t, s;
        z  = x << 15;
        z2 = (z * z) >> 30;
        t  = SIN_COEF[1] - ((z2 * SIN_COEF[0]) >> 30);
        t  = SIN_COEF[2] - ((z2 * t) >> 30);
        t  = SIN_COEF[3] - ((z2 * t) >> 30);
        t  = SIN_COEF[4] - ((z2 * t) >> 30);
        s  = (z * t) >> 30;
        return (s > SIN_ONE) ? longint'(SIN_ONE) : s;
    endfunction

    // full wave from quarter wave, angle in pi/65536 units
    function automatic longint wave_sine(input longint unsigned a);
        longint unsigned q, r, m;
        a = a & 131071;
        q = a >> 15;
        r = a & 32767;
        m = q[0] ? quarter_sine(32768 - r) : quarter_sine(r);
        return (q >= 2) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint round_away(input longint v, input int sh);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    task automatic predict(input logic mode, input logic [7:0] ring, input logic [7:0] seg);
        vertex_out_t e;
        bit ok;
        logic [31:0] stride, a, b;
        longint unsigned tu, tv;
        longint phi, sp, cp, st, ct, nx, ny, nz, r, hh, yoff;
        e = '{default: '0};
        if (mode == MODE_VERTEX)
            ok = rings != 0 && segs != 0 && ring <= rings && seg <= segs;
        else
            ok = ring < rings && seg < segs;
        if (!ok) begin
            e.last = 1'b1;
            e.range_error = 1'b1;
            vertex_q = {vertex_q, e};
        end else if (mode == MODE_INDEX) begin
            stride = segs + 32'd1;
            a = vbase + ring * stride + seg;
            b = a + stride;
            for (int k = 0; k < 6; k++) begin
                case (k)
                    0: e.index_value = a;
                    1, 4: e.index_value = b;
                    2, 3: e.index_value = a + 1;
                    default: e.index_value = b + 1;
                endcase
                e.last = (k == IDX_LAST);
                vertex_q = {vertex_q, e};
            end
        end else begin
            tu = (longint'(seg) * 131072 + segs) / (2 * longint'(segs));
            tv = (longint'(ring) * 131072 + rings) / (2 * longint'(rings));
            phi = longint'(sweep_lo)
                + round_away((longint'(sweep_hi) - longint'(sweep_lo)) * longint'(tv), 16);
            sp = wave_sine(phi & 131071);
            cp = wave_sine((phi & 131071) + 32768);
            st = wave_sine((2 * tu) & 131071);
            ct = wave_sine(((2 * tu) & 131071) + 32768);
            nx = round_away(sp * st, 30);
            ny = cp;
            nz = round_away(sp * ct, 30);
            r  = radius;
            hh = longint'(height) - 2 * r;
            hh = (hh > 0) ? hh / 2 : 0;
            yoff = (phi <= 32768) ? hh : -hh;
            e.pos_x  = 22'(round_away(nx * r, 30));
            e.pos_y  = 22'(round_away(ny * r, 30) + yoff);
            e.pos_z  = 22'(round_away(nz * r, 30));
            e.norm_x = 16'(round_away(nx, 16));
            e.norm_y = 16'(round_away(ny, 16));
            e.norm_z = 16'(round_away(nz, 16));
            e.tex_u  = 17'(tu);
            e.tex_v  = 17'(tv);
            e.last   = 1'b1;
            vertex_q = {vertex_q, e};
        end
    endtask

    task automatic compare(input vertex_out_t got);
        vertex_out_t e;
        e = vertex_q.pop_front();
        if (got !== e) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("mismatch: exp pos %h %h %h nrm %h %h %h uv %h %h idx %h l%b e%b",
                    e.pos_x, e.pos_y, e.pos_z, e.norm_x, e.norm_y, e.norm_z, e.tex_u,
                    e.tex_v, e.index_value, e.last, e.range_error);
                $display("          got pos %h %h %h nrm %h %h %h uv %h %h idx %h l%b e%b",
                    got.pos_x, got.pos_y, got.pos_z, got.norm_x, got.norm_y, got.norm_z,
                    got.tex_u, got.tex_v, got.index_value, got.last, got.range_error);
            end
        end
    endtask

    assign pending = vertex_q.size();

    // register shadow, input prediction and output comparison
    always @(posedge aclk) begin
        vertex_out_t got;
        if (!aresetn) begin
            rings <= 8'd16; segs <= 8'd16; radius <= 20'd2048; height <= '0;
            sweep_lo <= '0; sweep_hi <= 17'd65536; vbase <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_RING_COUNT:    rings    <= cfg_wdata[7:0];
                    REG_SEGMENT_COUNT: segs     <= cfg_wdata[7:0];
                    REG_LATHE_RADIUS:  radius   <= cfg_wdata[19:0];
                    REG_TOTAL_HEIGHT:  height   <= cfg_wdata[19:0];
                    REG_SWEEP_START:   sweep_lo <= cfg_wdata[16:0];
                    REG_SWEEP_END:     sweep_hi <= cfg_wdata[16:0];
                    REG_INDEX_BASE:    vbase    <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict(s_tuser, s_tdata[7:0], s_tdata[15:8]);
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.pos_x = m_tdata[21:0];     got.pos_y = m_tdata[43:22];
                got.pos_z = m_tdata[65:44];    got.norm_x = m_tdata[81:66];
                got.norm_y = m_tdata[97:82];   got.norm_z = m_tdata[113:98];
                got.tex_u = m_tdata[130:114];  got.tex_v = m_tdata[147:131];
                got.index_value = m_tdata[179:148];
                got.last = m_tlast;            got.range_error = m_tuser;
                if (vertex_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: idx %h l%b e%b",
                            got.index_value, got.last, got.range_error);
                end else
                    compare(got);
            end
        end
    end

    initial begin
        fail_count = 0;
        results_seen = 0;
    end

endmodule

// ----- dv/tb.sv -----
// Top of the lathe mesh vertex generator testbench: clock, reset, stimulus,
// register settings and verdict. Depends on lmvg_pkg and lmvg_checker.
`timescale 1ns / 100ps

module tb;
    import lmvg_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [15:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [183:0] m_tdata;
    wire          m_tuser;
    wire          m_tlast;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;

    int  fail_count, pending, results_seen;
    int  items_sent = 0;
    bit  calm = 1'b0;          // no idling on either side while set
    bit  took = 1'b0;
    int  rx_hold = 0;
    int  cur_rings = 16, cur_segs = 16;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    lathe_mesh_vertex_generator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    lmvg_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // result side back-pressure: fresh random stall, possibly none, after each transfer
    always @(posedge aclk)
        if (m_tvalid && m_tready) took = 1'b1;

    always @(negedge aclk) begin
        if (took) begin
            rx_hold = calm ? 0 : $urandom_range(0, 19);
            took = 1'b0;
        end
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else
            m_tready <= 1'b1;
    end

    // one input transfer; called and returns at a falling edge
    task automatic send_point(input logic mode, input logic [7:0] ring, input logic [7:0] seg);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {seg, ring};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic load_grid(input int rc, input int sc, input int rad, input int hgt,
                             input int sw_lo, input int sw_hi, input logic [31:0] base);
        write_reg(REG_RING_COUNT, rc);
        write_reg(REG_SEGMENT_COUNT, sc);
        write_reg(REG_LATHE_RADIUS, rad);
        write_reg(REG_TOTAL_HEIGHT, hgt);
        write_reg(REG_SWEEP_START, sw_lo);
        write_reg(REG_SWEEP_END, sw_hi);
        write_reg(REG_INDEX_BASE, base);
        write_reg(3'd7, 32'hFFFF_FFFF);     // unmapped index, must be ignored
        cfg_we <= 1'b0;
        cur_rings = rc;
        cur_segs  = sc;
    endtask

    // mostly in-grid points and quads, some arbitrary coordinates
    task automatic random_points(input int n);
        logic mode;
        logic [7:0] ring, seg;
        repeat (n) begin
            mode = $urandom_range(0, 1);
            ring = $urandom;
            seg  = $urandom;
            if ($urandom_range(0, 99) < 85 && cur_rings > 0 && cur_segs > 0) begin
                ring = $urandom_range(0, mode ? cur_rings - 1 : cur_rings);
                seg  = $urandom_range(0, mode ? cur_segs - 1 : cur_segs);
            end
            send_point(mode, ring, seg);
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed at reset values: corners, edges and out-of-grid cases
        send_point(MODE_VERTEX, 0, 0);
        send_point(MODE_VERTEX, 16, 16);
        send_point(MODE_VERTEX, 0, 16);
        send_point(MODE_VERTEX, 16, 0);
        send_point(MODE_VERTEX, 8, 4);
        send_point(MODE_VERTEX, 17, 0);
        send_point(MODE_VERTEX, 0, 17);
        send_point(MODE_VERTEX, 255, 255);
        send_point(MODE_INDEX, 0, 0);
        send_point(MODE_INDEX, 15, 15);
        send_point(MODE_INDEX, 16, 0);
        send_point(MODE_INDEX, 0, 16);
        send_point(MODE_INDEX, 255, 255);
        send_point(MODE_INDEX, 7, 3);
        settle();

        // zero counts: everything is out of grid
        load_grid(0, 0, 2048, 0, 0, 65536, 0);
        send_point(MODE_VERTEX, 0, 0);
        send_point(MODE_INDEX, 0, 0);
        settle();

        // largest grid, largest radius and height, index base near wrap
        load_grid(255, 255, 1048575, 1048575, 0, 65536, 32'hFFFF_FFF0);
        send_point(MODE_VERTEX, 255, 255);
        send_point(MODE_INDEX, 254, 254);
        random_points(20);
        settle();

        // smallest grid, swept backwards from just below 2 pi
        calm = 1'b1;
        load_grid(1, 1, 0, 4096, 131071, 0, 32'h8000_0000);
        random_points(12);
        settle();
        calm = 1'b0;

        // random settings, capsule heights and partial sweeps
        repeat (4) begin
            load_grid($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(0, 1048575),
                      $urandom_range(0, 1048575), $urandom_range(0, 131071),
                      $urandom_range(0, 131071), $urandom);
            calm = $urandom_range(0, 3) == 0;
            random_points(20);
            settle();
        end
        calm = 1'b0;

        $display("tb: %0d input transfers, %0d results; zero, smallest, largest, random grids",
                 items_sent, results_seen);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/lmvg_pkg.sv
hdl/lmvg_div.sv
hdl/lmvg_sin.sv
hdl/lathe_mesh_vertex_generator.sv
dv/lmvg_checker.sv
dv/tb.sv
